FILE: design/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// Shared codes, field widths and constants of the dirty span tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dst_pkg;

   // item field widths
   localparam int OP_W        = 2;
   localparam int RECT_W      = 16;
   localparam int ROW_IN_W    = 11;
   localparam int OUT_START_W = 12;
   localparam int OUT_LEN_W   = 13;

   // operation codes
   localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 13;
   localparam int SCR_W_W    = 13;
   localparam int SCR_H_W    = 12;

   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_QUARTER_X     = 2'd2;

   localparam logic [SCR_W_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
   localparam logic [SCR_H_W-1:0] RST_SCREEN_HEIGHT = 12'd480;

   // signed width for rectangle clipping
   localparam int CALC_W = 18;

   // table epoch tags: zero never matches, live epochs run first..last
   localparam int EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'd255;

endpackage

`default_nettype wire

FILE: design/dst_req_if.sv
// ----------------------------------------------------------------------------
// dst_req_if
// Request channel: mark, clear and read items with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dst_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [dst_pkg::OP_W-1:0]        op;
   logic signed [dst_pkg::RECT_W-1:0]      rect_x;
   logic signed [dst_pkg::RECT_W-1:0]      rect_y;
   logic signed [dst_pkg::RECT_W-1:0]      rect_width;
   logic signed [dst_pkg::RECT_W-1:0]      rect_height;
   logic        [dst_pkg::ROW_IN_W-1:0]    read_row;

   modport source (
      output valid, op, rect_x, rect_y, rect_width, rect_height, read_row,
      input  ready
   );

   modport sink (
      input  valid, op, rect_x, rect_y, rect_width, rect_height, read_row,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/dst_rsp_if.sv
// ----------------------------------------------------------------------------
// dst_rsp_if
// Response channel: redraw flag and the two spans of a row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dst_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                dirty_all;
   logic [dst_pkg::OUT_START_W-1:0]     first_start;
   logic [dst_pkg::OUT_LEN_W-1:0]       first_length;
   logic [dst_pkg::OUT_START_W-1:0]     second_start;
   logic [dst_pkg::OUT_LEN_W-1:0]       second_length;

   modport source (
      output valid, dirty_all, first_start, first_length, second_start, second_length,
      input  ready
   );

   modport sink (
      input  valid, dirty_all, first_start, first_length, second_start, second_length,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/dst_ram.sv
// ----------------------------------------------------------------------------
// dst_ram
// Span table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dst_ram #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11,
   parameter int WIDTH  = 58
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/dst_span_upd.sv
// ----------------------------------------------------------------------------
// dst_span_upd
// Row update pipeline: classify the row read from the table, then merge the
// column range into its spans and write the row back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dst_span_upd #(
   parameter int ROW_W   = 11,
   parameter int COL_W   = 13,
   parameter int START_W = 12,
   parameter int WORD_W  = 58
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        issue_vld,
   input  wire logic [ROW_W-1:0]            issue_row,
   input  wire logic [WORD_W-1:0]           rd_word,
   input  wire logic [dst_pkg::EPOCH_W-1:0] epoch,
   input  wire logic [COL_W-1:0]            col_x,
   input  wire logic [COL_W-1:0]            col_xe,
   input  wire logic [COL_W-1:0]            col_an,
   output logic                             busy,
   output logic                             wr_en,
   output logic      [ROW_W-1:0]            wr_row,
   output logic      [WORD_W-1:0]           wr_word
);

   typedef enum logic [2:0] {
      ACT_SET0   = 3'd0,
      ACT_SET1   = 3'd1,
      ACT_SHIFT  = 3'd2,
      ACT_WIDEN0 = 3'd3,
      ACT_WIDEN1 = 3'd4,
      ACT_BRIDGE = 3'd5
   } act_type;

   // stage 1: aligned with the registered read data
   logic             p1_vld_ff;
   logic [ROW_W-1:0] p1_row_ff;

   // stage 2: classified row
   logic               p2_vld_ff;
   logic [ROW_W-1:0]   p2_row_ff;
   act_type            p2_act_ff;
   act_type            act_in;
   logic [START_W-1:0] p2_s0_ff, p2_s1_ff;
   logic [COL_W-1:0]   p2_l0_ff, p2_l1_ff;
   logic [COL_W-1:0]   p2_bs_ff, p2_be_ff;
   logic [COL_W-1:0]   bs_in, be_in;

   logic [dst_pkg::EPOCH_W-1:0] rd_tag;
   logic [START_W-1:0]          rd_s0, rd_s1, s0, s1;
   logic [COL_W-1:0]            rd_l0, rd_l1, l0, l1;
   logic                        hit;
   logic [COL_W-1:0]            s0c, s1c, e0, e1, d1, d2;
   logic                        apart0, apart1, bridge;

   assign {rd_tag, rd_s0, rd_l0, rd_s1, rd_l1} = rd_word;

   // a row tagged with an older epoch was cleared
   assign hit = (rd_tag == epoch);
   assign s0  = hit ? rd_s0 : '0;
   assign l0  = hit ? rd_l0 : '0;
   assign s1  = hit ? rd_s1 : '0;
   assign l1  = hit ? rd_l1 : '0;

   assign s0c = COL_W'(s0);
   assign s1c = COL_W'(s1);
   assign e0  = s0c + l0;
   assign e1  = s1c + l1;

   assign apart0 = (col_x > e0) || (col_xe < s0c);
   assign apart1 = (col_x > e1) || (col_xe < s1c);
   assign bridge = (col_x <= e0) && (col_xe >= s1c);
   assign d1     = (col_xe < s0c) ? (s0c - col_xe) : (col_x - e0);
   assign d2     = (col_xe < s1c) ? (s1c - col_xe) : (col_x - e1);

   always_comb begin
      act_in = ACT_WIDEN0;
      bs_in  = s0c;
      be_in  = e0;
      priority if (l0 == '0) begin
         act_in = ACT_SET0;
      end else if (l1 == '0) begin
         if (apart0) begin
            act_in = (col_x > s0c) ? ACT_SET1 : ACT_SHIFT;
         end else begin
            act_in = ACT_WIDEN0;
         end
      end else if (bridge) begin
         act_in = ACT_BRIDGE;
         be_in  = e1;
      end else if (!apart0) begin
         act_in = ACT_WIDEN0;
      end else if (!apart1 || (d1 > d2)) begin
         act_in = ACT_WIDEN1;
         bs_in  = s1c;
         be_in  = e1;
      end else begin
         act_in = ACT_WIDEN0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= issue_vld;
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_row_ff <= issue_row;
      p2_row_ff <= p1_row_ff;
      p2_act_ff <= act_in;
      p2_s0_ff  <= s0;
      p2_l0_ff  <= l0;
      p2_s1_ff  <= s1;
      p2_l1_ff  <= l1;
      p2_bs_ff  <= bs_in;
      p2_be_ff  <= be_in;
   end

   // write stage: set, shift, widen or bridge the spans to take in the column range
   logic [COL_W-1:0]   new_s, new_e, new_l;
   logic [START_W-1:0] s0n, s1n;
   logic [COL_W-1:0]   l0n, l1n;

   assign new_s = (col_x < p2_bs_ff) ? col_x : p2_bs_ff;
   assign new_e = (col_xe > p2_be_ff) ? col_xe : p2_be_ff;
   assign new_l = new_e - new_s;

   always_comb begin
      s0n = p2_s0_ff;
      l0n = p2_l0_ff;
      s1n = p2_s1_ff;
      l1n = p2_l1_ff;
      unique case (p2_act_ff)
         ACT_SET0: begin
            s0n = START_W'(col_x);
            l0n = col_an;
         end
         ACT_SET1: begin
            s1n = START_W'(col_x);
            l1n = col_an;
         end
         ACT_SHIFT: begin
            s1n = p2_s0_ff;
            l1n = p2_l0_ff;
            s0n = START_W'(col_x);
            l0n = col_an;
         end
         ACT_WIDEN0: begin
            s0n = START_W'(new_s);
            l0n = new_l;
         end
         ACT_WIDEN1: begin
            s1n = START_W'(new_s);
            l1n = new_l;
         end
         ACT_BRIDGE: begin
            s0n = START_W'(new_s);
            l0n = new_l;
            s1n = '0;
            l1n = '0;
         end
         default: begin
            s0n = p2_s0_ff;
         end
      endcase
   end

   assign wr_en   = p2_vld_ff;
   assign wr_row  = p2_row_ff;
   assign wr_word = {epoch, s0n, l0n, s1n, l1n};
   assign busy    = p1_vld_ff | p2_vld_ff;

endmodule

`default_nettype wire

FILE: design/dirty_span_tracker.sv
// ----------------------------------------------------------------------------
// dirty_span_tracker
// Mark: walks the clipped rows, one table row per cycle, reading each through
//   the read port and writing it back through the write port.
// Throughput: one item at a time; the next item is taken once the current
//   one is handed to the output register.
// Reset: a clearing pass writes all MAX_ROWS table rows, one per cycle; every
//   255th clear item repeats that pass before its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dirty_span_tracker #(
   parameter int MAX_ROWS    = 2048,
   parameter int MAX_COLUMNS = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   dst_req_if.sink                                req_ch,
   dst_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [dst_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [dst_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
   localparam int START_W = $clog2(MAX_COLUMNS);
   localparam int WORD_W  = dst_pkg::EPOCH_W + 2 * COL_W + 2 * START_W;
   localparam int CALC_W  = dst_pkg::CALC_W;
   localparam int OS_W    = dst_pkg::OUT_START_W;
   localparam int OL_W    = dst_pkg::OUT_LEN_W;

   localparam logic signed [CALC_W-1:0] COLS_LIM = CALC_W'(MAX_COLUMNS);
   localparam logic signed [CALC_W-1:0] ROWS_LIM = CALC_W'(MAX_ROWS);

   typedef enum logic [8:0] {
      S_SCRUB  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_CLIP   = 9'b000000100,
      S_PREP   = 9'b000001000,
      S_MARK   = 9'b000010000,
      S_DRAIN  = 9'b000100000,
      S_RDADDR = 9'b001000000,
      S_RDDATA = 9'b010000000,
      S_RESP   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [dst_pkg::SCR_W_W-1:0] scr_w_ff;
   logic [dst_pkg::SCR_H_W-1:0] scr_h_ff;
   logic                        quarter_ff;
   logic                        redraw_ff;
   logic [dst_pkg::EPOCH_W-1:0] epoch_ff;
   logic [ROW_W-1:0]            scrub_row_ff;
   logic                        scrub_rsp_ff;
   logic                        scrub_last;

   logic signed [dst_pkg::RECT_W-1:0] rect_x_ff, rect_y_ff, rect_w_ff, rect_h_ff;
   logic [dst_pkg::ROW_IN_W-1:0]      read_row_ff;

   logic [COL_W-1:0] x_lo_ff, x_hi_ff, col_x_ff, col_xe_ff, col_an;
   logic [COL_W-1:0] col_x_in, col_xe_in;
   logic [ROW_W-1:0] y_lo_ff, y_last_ff, row_ff;

   logic [OS_W-1:0] res_s0_ff, res_s1_ff, out_s0_ff, out_s1_ff;
   logic [OL_W-1:0] res_l0_ff, res_l1_ff, out_l0_ff, out_l1_ff;
   logic            out_flag_ff;
   logic            rsp_vld_ff;

   logic accept, rsp_load;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_load     = (state_ff == S_RESP) && (!rsp_vld_ff || rsp_ch.ready);

   // ---------------- rectangle clipping ----------------
   logic signed [CALC_W-1:0] cx, cy, cw, ch, sw_c, sh_c, lim_w, lim_h;
   logic signed [CALC_W-1:0] x_end, y_end, x_lo, y_lo, x_hi, y_hi;
   logic                     full_screen, clip_ok;

   assign cx   = CALC_W'(rect_x_ff);
   assign cy   = CALC_W'(rect_y_ff);
   assign cw   = CALC_W'(rect_w_ff);
   assign ch   = CALC_W'(rect_h_ff);
   assign sw_c = CALC_W'(scr_w_ff);
   assign sh_c = CALC_W'(scr_h_ff);

   assign full_screen = (cw == sw_c) && (ch == sh_c) && (cx == '0) && (cy == '0);

   assign lim_w = (sw_c > COLS_LIM) ? COLS_LIM : sw_c;
   assign lim_h = (sh_c > ROWS_LIM) ? ROWS_LIM : sh_c;
   assign x_end = cx + cw;
   assign y_end = cy + ch;
   assign x_lo  = cx[CALC_W-1] ? '0 : cx;
   assign y_lo  = cy[CALC_W-1] ? '0 : cy;
   assign x_hi  = (x_end > lim_w) ? lim_w : x_end;
   assign y_hi  = (y_end > lim_h) ? lim_h : y_end;
   assign clip_ok = (x_hi > x_lo) && (y_hi > y_lo);

   // quarter the column range for planar modes
   assign col_x_in  = quarter_ff ? (x_lo_ff >> 2) : x_lo_ff;
   assign col_xe_in = quarter_ff ? (((x_hi_ff - COL_W'(1)) >> 2) + COL_W'(1)) : x_hi_ff;
   assign col_an    = col_xe_ff - col_x_ff;

   // ---------------- span table ----------------
   logic                        mem_wr_en, mem_rd_en;
   logic [ROW_W-1:0]            mem_wr_addr, mem_rd_addr;
   logic [WORD_W-1:0]           mem_wr_data, rd_word;
   logic                        upd_busy, upd_wr_en, issue_vld;
   logic [ROW_W-1:0]            upd_wr_row;
   logic [WORD_W-1:0]           upd_wr_word;

   assign issue_vld   = (state_ff == S_MARK);
   assign mem_rd_en   = issue_vld || (state_ff == S_RDADDR);
   assign mem_rd_addr = (state_ff == S_RDADDR) ? ROW_W'(read_row_ff) : row_ff;
   assign mem_wr_en   = (state_ff == S_SCRUB) || upd_wr_en;
   assign mem_wr_addr = (state_ff == S_SCRUB) ? scrub_row_ff : upd_wr_row;
   // an all-zero word carries a tag no live epoch uses
   assign mem_wr_data = (state_ff == S_SCRUB) ? '0 : upd_wr_word;

   dst_ram #(
      .DEPTH  (MAX_ROWS),
      .ADDR_W (ROW_W),
      .WIDTH  (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_word)
   );

   dst_span_upd #(
      .ROW_W   (ROW_W),
      .COL_W   (COL_W),
      .START_W (START_W),
      .WORD_W  (WORD_W)
   ) u_upd (
      .clock     (clock),
      .reset     (reset),
      .issue_vld (issue_vld),
      .issue_row (row_ff),
      .rd_word   (rd_word),
      .epoch     (epoch_ff),
      .col_x     (col_x_ff),
      .col_xe    (col_xe_ff),
      .col_an    (col_an),
      .busy      (upd_busy),
      .wr_en     (upd_wr_en),
      .wr_row    (upd_wr_row),
      .wr_word   (upd_wr_word)
   );

   // read-back decode
   logic [dst_pkg::EPOCH_W-1:0] rd_tag;
   logic [START_W-1:0]          rd_s0, rd_s1;
   logic [COL_W-1:0]            rd_l0, rd_l1;
   logic                        rd_use;

   assign {rd_tag, rd_s0, rd_l0, rd_s1, rd_l1} = rd_word;
   assign rd_use = (rd_tag == epoch_ff) && (int'(read_row_ff) < MAX_ROWS);

   // ---------------- control ----------------
   assign scrub_last = (scrub_row_ff == ROW_W'(MAX_ROWS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_SCRUB: begin
            if (scrub_last) begin
               state_in = scrub_rsp_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               unique case (req_ch.op)
                  dst_pkg::OP_MARK:  state_in = S_CLIP;
                  dst_pkg::OP_CLEAR: begin
                     state_in = (epoch_ff == dst_pkg::EPOCH_LAST) ? S_SCRUB : S_RESP;
                  end
                  dst_pkg::OP_READ:  state_in = S_RDADDR;
                  default:           state_in = S_RESP;
               endcase
            end
         end
         S_CLIP: begin
            state_in = (!full_screen && clip_ok) ? S_PREP : S_RESP;
         end
         S_PREP:   state_in = S_MARK;
         S_MARK: begin
            if (row_ff == y_last_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!upd_busy) begin
               state_in = S_RESP;
            end
         end
         S_RDADDR: state_in = S_RDDATA;
         S_RDDATA: state_in = S_RESP;
         S_RESP: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SCRUB;
         scr_w_ff     <= dst_pkg::RST_SCREEN_WIDTH;
         scr_h_ff     <= dst_pkg::RST_SCREEN_HEIGHT;
         quarter_ff   <= 1'b0;
         redraw_ff    <= 1'b0;
         epoch_ff     <= dst_pkg::EPOCH_FIRST;
         scrub_row_ff <= '0;
         scrub_rsp_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         row_ff       <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_addr)
               dst_pkg::CSR_SCREEN_WIDTH:  scr_w_ff   <= csr_wdata[dst_pkg::SCR_W_W-1:0];
               dst_pkg::CSR_SCREEN_HEIGHT: scr_h_ff   <= csr_wdata[dst_pkg::SCR_H_W-1:0];
               dst_pkg::CSR_QUARTER_X:     quarter_ff <= csr_wdata[0];
               default:                    quarter_ff <= quarter_ff;
            endcase
         end

         if (state_ff == S_SCRUB) begin
            if (scrub_last) begin
               scrub_row_ff <= '0;
               scrub_rsp_ff <= 1'b0;
               epoch_ff     <= dst_pkg::EPOCH_FIRST;
            end else begin
               scrub_row_ff <= scrub_row_ff + ROW_W'(1);
            end
         end

         // clear: retire the epoch, or sweep the table when tags run out
         if (accept && (req_ch.op == dst_pkg::OP_CLEAR)) begin
            redraw_ff <= 1'b0;
            if (epoch_ff == dst_pkg::EPOCH_LAST) begin
               scrub_rsp_ff <= 1'b1;
            end else begin
               epoch_ff <= epoch_ff + dst_pkg::EPOCH_W'(1);
            end
         end

         if ((state_ff == S_CLIP) && full_screen) begin
            redraw_ff <= 1'b1;
         end

         if (state_ff == S_PREP) begin
            row_ff <= y_lo_ff;
         end else if (state_ff == S_MARK) begin
            row_ff <= row_ff + ROW_W'(1);
         end

         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         rect_x_ff   <= req_ch.rect_x;
         rect_y_ff   <= req_ch.rect_y;
         rect_w_ff   <= req_ch.rect_width;
         rect_h_ff   <= req_ch.rect_height;
         read_row_ff <= req_ch.read_row;
         res_s0_ff   <= '0;
         res_l0_ff   <= '0;
         res_s1_ff   <= '0;
         res_l1_ff   <= '0;
      end

      if (state_ff == S_CLIP) begin
         x_lo_ff   <= COL_W'(x_lo);
         x_hi_ff   <= COL_W'(x_hi);
         y_lo_ff   <= ROW_W'(y_lo);
         y_last_ff <= ROW_W'(y_hi - CALC_W'(1));
      end

      if (state_ff == S_PREP) begin
         col_x_ff  <= col_x_in;
         col_xe_ff <= col_xe_in;
      end

      if (state_ff == S_RDDATA) begin
         res_s0_ff <= rd_use ? OS_W'(rd_s0) : '0;
         res_l0_ff <= rd_use ? OL_W'(rd_l0) : '0;
         res_s1_ff <= rd_use ? OS_W'(rd_s1) : '0;
         res_l1_ff <= rd_use ? OL_W'(rd_l1) : '0;
      end

      if (rsp_load) begin
         out_flag_ff <= redraw_ff;
         out_s0_ff   <= res_s0_ff;
         out_l0_ff   <= res_l0_ff;
         out_s1_ff   <= res_s1_ff;
         out_l1_ff   <= res_l1_ff;
      end
   end

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.dirty_all     = out_flag_ff;
   assign rsp_ch.first_start   = out_s0_ff;
   assign rsp_ch.first_length  = out_l0_ff;
   assign rsp_ch.second_start  = out_s1_ff;
   assign rsp_ch.second_length = out_l1_ff;

endmodule

`default_nettype wire

FILE: sim/dirty_span_tracker_test.sv
// ----------------------------------------------------------------------------
// dirty_span_tracker_test
// Drives mark, clear and read items into the span tracker under random
// backpressure on both channels. A local copy of the span table predicts
// every result and the monitor checks each one field by field. Runs cover
// several screen geometries, quartered x, epoch wrap of the table clears and
// both clipping extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dirty_span_tracker_test;
   import dst_pkg::*;

   localparam int TABLE_ROWS  = 2048;
   localparam int TABLE_COLS  = 4096;
   localparam int STALL_LIMIT = 20000;

   // op code 3 is not used by the block
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   typedef struct packed {
      logic        [OP_W-1:0]     op;
      logic signed [RECT_W-1:0]   rect_x;
      logic signed [RECT_W-1:0]   rect_y;
      logic signed [RECT_W-1:0]   rect_width;
      logic signed [RECT_W-1:0]   rect_height;
      logic        [ROW_IN_W-1:0] read_row;
   } span_req_type;

   typedef struct packed {
      logic                   dirty_all;
      logic [OUT_START_W-1:0] first_start;
      logic [OUT_LEN_W-1:0]   first_length;
      logic [OUT_START_W-1:0] second_start;
      logic [OUT_LEN_W-1:0]   second_length;
   } span_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dst_req_if req_ch ();
   dst_rsp_if rsp_ch ();

   dirty_span_tracker #(
      .MAX_ROWS    (TABLE_ROWS),
      .MAX_COLUMNS (TABLE_COLS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // local copy of the span table and the screen setup; the table starts at zero
   int        first_pos  [0:TABLE_ROWS-1];
   int        first_len  [0:TABLE_ROWS-1];
   int        second_pos [0:TABLE_ROWS-1];
   int        second_len [0:TABLE_ROWS-1];
   bit        redraw_flag;
   int        cfg_width;
   int        cfg_height;
   bit        cfg_quarter;

   span_req_type queued_items [$];
   span_rsp_type expected_spans [$];
   span_req_type item_on_bus;
   span_rsp_type head;
   int           mismatches;
   int           idle_cycles;
   int           row_base;
   bit           steady;

   // widen the first (sel = 0) or second span of row r to cover [x, x + n)
   function automatic void widen_span(int r, bit sel, int x, int n);
      int s, l, e;
      s = sel ? second_pos[r] : first_pos[r];
      l = sel ? second_len[r] : first_len[r];
      e = s + l;
      if (x < s) s = x;
      if (x + n > e) e = x + n;
      l = e - s;
      if (sel) begin
         second_pos[r] = s;
         second_len[r] = l;
      end else begin
         first_pos[r] = s;
         first_len[r] = l;
      end
   endfunction

   // update the span table for one item and return the result it yields
   function automatic span_rsp_type apply_to_table(span_req_type it);
      span_rsp_type res;
      int x, y, n, m, wc, hc, xe, xmax, ymax, e, d1, d2, r;
      res = '0;
      case (it.op)
         OP_MARK: begin
            x  = it.rect_x;
            y  = it.rect_y;
            n  = it.rect_width;
            m  = it.rect_height;
            wc = (cfg_width < TABLE_COLS) ? cfg_width : TABLE_COLS;
            hc = (cfg_height < TABLE_ROWS) ? cfg_height : TABLE_ROWS;
            if (n == cfg_width && m == cfg_height && x == 0 && y == 0) begin
               redraw_flag = 1'b1;
            end else if (!(n <= 0 || m <= 0 || x >= wc || y >= hc)) begin
               if (x < 0) begin
                  n = n + x;
                  x = 0;
               end
               if (y < 0) begin
                  m = m + y;
                  y = 0;
               end
               if (x + n > wc) n = wc - x;
               if (y + m > hc) m = hc - y;
               if (n > 0 && m > 0) begin
                  xmax = x + n - 1;
                  ymax = y + m - 1;
                  if (cfg_quarter) begin
                     x    = x >>> 2;
                     xmax = xmax >>> 2;
                     n    = xmax - x + 1;
                  end
                  xe = x + n;
                  for (r = y; r <= ymax; r++) begin
                     if (first_len[r] == 0) begin
                        first_pos[r] = x;
                        first_len[r] = n;
                     end else if (second_len[r] == 0) begin
                        if (x > first_pos[r] + first_len[r] || xe < first_pos[r]) begin
                           if (x > first_pos[r]) begin
                              second_pos[r] = x;
                              second_len[r] = n;
                           end else begin
                              second_pos[r] = first_pos[r];
                              second_len[r] = first_len[r];
                              first_pos[r]  = x;
                              first_len[r]  = n;
                           end
                        end else begin
                           widen_span(r, 1'b0, x, n);
                        end
                     end else if (x <= first_pos[r] + first_len[r] && xe >= second_pos[r]) begin
                        // bridge both spans into the first one
                        e = second_pos[r] + second_len[r];
                        if (x < first_pos[r]) first_pos[r] = x;
                        if (xe > e) e = xe;
                        first_len[r]  = e - first_pos[r];
                        second_pos[r] = 0;
                        second_len[r] = 0;
                     end else if (!(x > first_pos[r] + first_len[r] || xe < first_pos[r])) begin
                        widen_span(r, 1'b0, x, n);
                     end else if (!(x > second_pos[r] + second_len[r] || xe < second_pos[r])) begin
                        widen_span(r, 1'b1, x, n);
                     end else begin
                        d1 = (xe < first_pos[r]) ? first_pos[r] - xe
                                                 : x - (first_pos[r] + first_len[r]);
                        d2 = (xe < second_pos[r]) ? second_pos[r] - xe
                                                  : x - (second_pos[r] + second_len[r]);
                        widen_span(r, d1 > d2, x, n);
                     end
                  end
               end
            end
         end
         OP_CLEAR: begin
            for (r = 0; r < TABLE_ROWS; r++) begin
               first_pos[r]  = 0;
               first_len[r]  = 0;
               second_pos[r] = 0;
               second_len[r] = 0;
            end
            redraw_flag = 1'b0;
         end
         OP_READ: begin
            r = it.read_row;
            res.first_start   = first_pos[r][OUT_START_W-1:0];
            res.first_length  = first_len[r][OUT_LEN_W-1:0];
            res.second_start  = second_pos[r][OUT_START_W-1:0];
            res.second_length = second_len[r][OUT_LEN_W-1:0];
         end
         default: ;
      endcase
      res.dirty_all = redraw_flag;
      return res;
   endfunction

   function automatic span_req_type pick_item();
      span_req_type it;
      logic [31:0]  r0, r1, r2;
      int           roll, wc, hc, x, y, n, m;
      wc = (cfg_width < TABLE_COLS) ? cfg_width : TABLE_COLS;
      hc = (cfg_height < TABLE_ROWS) ? cfg_height : TABLE_ROWS;
      r0 = $urandom;
      r1 = $urandom;
      r2 = $urandom;
      it.op          = OP_MARK;
      it.rect_x      = r0[15:0];
      it.rect_y      = r0[31:16];
      it.rect_width  = r1[15:0];
      it.rect_height = r1[31:16];
      it.read_row    = r2[ROW_IN_W-1:0];
      roll = $urandom_range(99);
      if (roll < 3) begin
         it.op = OP_CLEAR;
      end else if (roll < 5) begin
         it.op = OP_SPARE;
      end else if (roll < 32) begin
         it.op = OP_READ;
         if ($urandom_range(4) != 0) begin
            y = row_base + int'($urandom_range(15));
            it.read_row = y[ROW_IN_W-1:0];
         end
      end else begin
         roll = $urandom_range(99);
         if (roll < 4) begin
            it.rect_x      = '0;
            it.rect_y      = '0;
            it.rect_width  = cfg_width[RECT_W-1:0];
            it.rect_height = cfg_height[RECT_W-1:0];
         end else if (roll >= 14) begin
            // keep rows in a narrow band so spans pile up
            x = int'($urandom_range(wc + 15)) - 8;
            n = 1 + int'($urandom_range(wc / 8 + 2));
            y = row_base + int'($urandom_range(17)) - 2;
            roll = $urandom_range(99);
            if (roll < 90)
               m = 1 + int'($urandom_range(3));
            else if (roll < 98)
               m = 1 + int'($urandom_range(31));
            else
               m = 1 + int'($urandom_range(hc + 8));
            it.rect_x      = x[RECT_W-1:0];
            it.rect_y      = y[RECT_W-1:0];
            it.rect_width  = n[RECT_W-1:0];
            it.rect_height = m[RECT_W-1:0];
         end
      end
      return it;
   endfunction

   task automatic push_item(logic [OP_W-1:0] op, int x, int y, int w, int h, int row);
      span_req_type it;
      it.op          = op;
      it.rect_x      = x[RECT_W-1:0];
      it.rect_y      = y[RECT_W-1:0];
      it.rect_width  = w[RECT_W-1:0];
      it.rect_height = h[RECT_W-1:0];
      it.read_row    = row[ROW_IN_W-1:0];
      queued_items.push_back(it);
   endtask

   // return at a falling edge once every item is in and every result is out
   task automatic wait_drained();
      do
         @(negedge clock);
      while (queued_items.size() != 0 || req_ch.valid || expected_spans.size() != 0);
   endtask

   task automatic set_screen(int w, int h, bit q);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_SCREEN_WIDTH;
      csr_wdata <= w[12:0];
      @(posedge clock);
      csr_addr  <= CSR_SCREEN_HEIGHT;
      csr_wdata <= {1'b0, h[11:0]};
      @(posedge clock);
      csr_addr  <= CSR_QUARTER_X;
      csr_wdata <= {12'd0, q};
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_width   = w & 'h1FFF;
      cfg_height  = h & 'hFFF;
      cfg_quarter = q;
      @(negedge clock);
   endtask

   task automatic run_phase(int count);
      int hc;
      hc = (cfg_height < TABLE_ROWS) ? cfg_height : TABLE_ROWS;
      row_base = (hc > 16) ? int'($urandom_range(hc - 16)) : 0;
      repeat (count) queued_items.push_back(pick_item());
      wait_drained();
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // item driver: predict on acceptance, then offer the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.op          <= OP_MARK;
         req_ch.rect_x      <= '0;
         req_ch.rect_y      <= '0;
         req_ch.rect_width  <= '0;
         req_ch.rect_height <= '0;
         req_ch.read_row    <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_spans.push_back(apply_to_table(item_on_bus));
         if (!req_ch.valid || req_ch.ready) begin
            if (queued_items.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
               item_on_bus = queued_items.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.op          <= item_on_bus.op;
               req_ch.rect_x      <= item_on_bus.rect_x;
               req_ch.rect_y      <= item_on_bus.rect_y;
               req_ch.rect_width  <= item_on_bus.rect_width;
               req_ch.rect_height <= item_on_bus.rect_height;
               req_ch.read_row    <= item_on_bus.read_row;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_spans.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with no item outstanding", $realtime);
            end else begin
               head = expected_spans.pop_front();
               check_field("dirty_all", head.dirty_all, rsp_ch.dirty_all);
               check_field("first_start", head.first_start, rsp_ch.first_start);
               check_field("first_length", head.first_length, rsp_ch.first_length);
               check_field("second_start", head.second_start, rsp_ch.second_start);
               check_field("second_length", head.second_length, rsp_ch.second_length);
            end
         end
         rsp_ch.ready <= steady || ($urandom_range(99) >= 24);
      end
   end

   // watchdog: count busy cycles in which no item moves on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (queued_items.size() == 0 && !req_ch.valid && expected_spans.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("dirty_span_tracker_test: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_addr           = CSR_SCREEN_WIDTH;
      csr_wdata          = '0;
      steady             = 1'b0;
      row_base           = 0;
      cfg_width          = RST_SCREEN_WIDTH;
      cfg_height         = RST_SCREEN_HEIGHT;
      cfg_quarter        = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items on the reset geometry
      push_item(OP_READ, 0, 0, 0, 0, 0);
      push_item(OP_MARK, 0, 0, 640, 480, 0);        // whole screen: flag only
      push_item(OP_READ, 0, 0, 0, 0, 5);
      push_item(OP_CLEAR, 0, 0, 0, 0, 0);
      push_item(OP_MARK, 10, 2, 5, 2, 0);           // fill empty rows
      push_item(OP_MARK, 40, 2, 10, 1, 0);          // second span to the right
      push_item(OP_MARK, 0, 3, 3, 1, 0);            // new span lands left of first
      push_item(OP_READ, 0, 0, 0, 0, 2);
      push_item(OP_READ, 0, 0, 0, 0, 3);
      push_item(OP_MARK, 13, 2, 4, 1, 0);           // overlaps first
      push_item(OP_MARK, 20, 2, 5, 1, 0);           // gap, first is nearer
      push_item(OP_MARK, 47, 2, 1, 1, 0);           // inside second
      push_item(OP_MARK, 34, 2, 2, 1, 0);           // gap, second is nearer
      push_item(OP_MARK, 2, 3, 10, 1, 0);           // bridges both spans
      push_item(OP_READ, 0, 0, 0, 0, 2);
      push_item(OP_READ, 0, 0, 0, 0, 3);
      push_item(OP_MARK, -5, -3, 10, 6, 0);         // clip top-left
      push_item(OP_MARK, 630, 475, 100, 100, 0);    // clip bottom-right
      push_item(OP_MARK, 5, 5, 0, -1, 0);
      push_item(OP_MARK, 640, 0, 4, 4, 0);
      push_item(OP_SPARE, -1, -1, -1, -1, 2047);
      push_item(OP_MARK, -32768, -32768, 32767, 32767, 0);
      push_item(OP_MARK, 32767, 32767, -32768, -32768, 2047);
      push_item(OP_READ, 0, 0, 0, 0, 0);
      push_item(OP_READ, 0, 0, 0, 0, 2047);
      wait_drained();

      // run the clear epoch past its wrap; rows 0..63 stay stale meanwhile
      push_item(OP_CLEAR, 0, 0, 0, 0, 0);
      push_item(OP_MARK, 100, 0, 50, 64, 0);
      for (int i = 0; i < 258; i++) begin
         push_item(OP_CLEAR, 0, 0, 0, 0, 0);
         if (i % 6 == 0) begin
            push_item(OP_MARK, 8 * (i % 50), 100 + i % 8, 20, 1, 0);
            push_item(OP_READ, 0, 0, 0, 0, 100 + i % 8);
            push_item(OP_READ, 0, 0, 0, 0, int'($urandom_range(63)));
         end
      end
      for (int i = 0; i < 8; i++)
         push_item(OP_READ, 0, 0, 0, 0, 8 * i + int'($urandom_range(7)));
      wait_drained();

      set_screen(TABLE_COLS, TABLE_ROWS, 1'b0);
      run_phase(80);
      set_screen(1, 1, 1'b1);
      run_phase(30);
      set_screen(8191, 4095, 1'b1);
      run_phase(80);
      set_screen(0, 0, 1'b0);
      run_phase(20);
      steady = 1'b1;
      set_screen(320, 200, 1'b1);
      run_phase(120);
      steady = 1'b0;
      set_screen(16 + int'($urandom_range(1008)), 16 + int'($urandom_range(240)),
                 1'($urandom_range(1)));
      run_phase(70);
      set_screen(RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, 1'b0);
      run_phase(80);

      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("dirty_span_tracker_test: done, clean");
      else
         $display("dirty_span_tracker_test: done, errors");
      $finish;
   end

endmodule
